>>> rtl/hbs_pkg.sv
`default_nettype none

package hbs_pkg;

    localparam int UNIV_BITS_DEF = 18;
    localparam int FUNC_W        = 3;
    localparam int WORD_W        = 64;
    localparam int DIGIT_W       = 6;
    localparam int MAX_LEVELS    = 4;

    localparam logic [FUNC_W-1:0] FN_INSERT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_DELETE = 3'd1;
    localparam logic [FUNC_W-1:0] FN_PRED   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_SUCC   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_MIN    = 3'd4;
    localparam logic [FUNC_W-1:0] FN_MAX    = 3'd5;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD_RD,
        ST_UPD_WR,
        ST_QRY_RD,
        ST_QRY_EV,
        ST_DSC_RD,
        ST_DSC_EV,
        ST_EMIT
    } t_step;

    typedef enum logic [1:0] {
        ASEL_X,
        ASEL_ANS,
        ASEL_CLR
    } t_asel;

    typedef enum logic [2:0] {
        DP_NONE,
        DP_CLEAR,
        DP_LOAD,
        DP_UPDATE,
        DP_QUERY,
        DP_DESCEND,
        DP_EMIT
    } t_dpop;

    typedef enum logic [2:0] {
        C_NONE,
        C_CLEAR,
        C_DISPATCH,
        C_UPDATE,
        C_QUERY,
        C_DESCEND,
        C_EMIT
    } t_cond;

    typedef struct packed {
        logic  mem_rd;
        logic  mem_wr;
        logic  wr_zero;
        logic  in_rdy;
        t_asel asel;
        t_dpop dp;
        t_cond cond;
        t_step next;
        t_step jmp;
        t_step alt;
    } t_uword;

    typedef struct packed {
        logic accept;
        logic clr_last;
        logic upd_stop;
        logic qry_emit;
        logic qry_hit;
        logic dsc_emit;
        logic out_free;
    } t_stat;

    // words held by one level of the tree, zero above the root
    function automatic int lvl_words(input int u, input int levels, input int lv);
        int sh;
        sh = u - DIGIT_W * (lv + 1);
        if (lv >= levels) begin
            return 0;
        end
        if (sh < 0) begin
            sh = 0;
        end
        return 1 << sh;
    endfunction

    function automatic int lvl_base(input int u, input int levels, input int lv);
        int sum;
        sum = 0;
        for (int j = 0; j < MAX_LEVELS; j++) begin
            if (j < lv) begin
                sum = sum + lvl_words(u, levels, j);
            end
        end
        return sum;
    endfunction

    function automatic logic [DIGIT_W-1:0] low_bit(input logic [WORD_W-1:0] v);
        logic [DIGIT_W-1:0] pos;
        pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                pos = DIGIT_W'(i);
            end
        end
        return pos;
    endfunction

    function automatic logic [DIGIT_W-1:0] high_bit(input logic [WORD_W-1:0] v);
        logic [DIGIT_W-1:0] pos;
        pos = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (v[i]) begin
                pos = DIGIT_W'(i);
            end
        end
        return pos;
    endfunction

    // entry step of each operation
    function automatic t_step dispatch(input logic [FUNC_W-1:0] func);
        t_step s;
        case (func) inside
            FN_INSERT, FN_DELETE: s = ST_UPD_RD;
            FN_PRED, FN_SUCC:     s = ST_QRY_RD;
            FN_MIN, FN_MAX:       s = ST_DSC_RD;
            default:              s = ST_IDLE;
        endcase
        return s;
    endfunction

    // control store
    function automatic t_uword ucode(input t_step step);
        t_uword uw;
        uw         = '0;
        uw.asel    = ASEL_X;
        uw.dp      = DP_NONE;
        uw.cond    = C_NONE;
        uw.next    = ST_IDLE;
        uw.jmp     = ST_IDLE;
        uw.alt     = ST_IDLE;
        case (step)
            ST_CLEAR: begin
                uw.mem_wr  = 1'b1;
                uw.wr_zero = 1'b1;
                uw.asel    = ASEL_CLR;
                uw.dp      = DP_CLEAR;
                uw.cond    = C_CLEAR;
                uw.next    = ST_CLEAR;
                uw.jmp     = ST_IDLE;
            end
            ST_IDLE: begin
                uw.in_rdy = 1'b1;
                uw.dp     = DP_LOAD;
                uw.cond   = C_DISPATCH;
                uw.next   = ST_IDLE;
            end
            ST_UPD_RD: begin
                uw.mem_rd = 1'b1;
                uw.next   = ST_UPD_WR;
            end
            ST_UPD_WR: begin
                uw.mem_wr = 1'b1;
                uw.dp     = DP_UPDATE;
                uw.cond   = C_UPDATE;
                uw.next   = ST_UPD_RD;
                uw.jmp    = ST_IDLE;
            end
            ST_QRY_RD: begin
                uw.mem_rd = 1'b1;
                uw.next   = ST_QRY_EV;
            end
            ST_QRY_EV: begin
                uw.dp   = DP_QUERY;
                uw.cond = C_QUERY;
                uw.next = ST_QRY_RD;
                uw.jmp  = ST_EMIT;
                uw.alt  = ST_DSC_RD;
            end
            ST_DSC_RD: begin
                uw.mem_rd = 1'b1;
                uw.asel   = ASEL_ANS;
                uw.next   = ST_DSC_EV;
            end
            ST_DSC_EV: begin
                uw.asel = ASEL_ANS;
                uw.dp   = DP_DESCEND;
                uw.cond = C_DESCEND;
                uw.next = ST_DSC_RD;
                uw.jmp  = ST_EMIT;
            end
            ST_EMIT: begin
                uw.dp   = DP_EMIT;
                uw.cond = C_EMIT;
                uw.next = ST_EMIT;
                uw.jmp  = ST_IDLE;
            end
            default: begin
                uw.next = ST_IDLE;
            end
        endcase
        return uw;
    endfunction

endpackage

`default_nettype wire

>>> rtl/hbs_if.sv
`default_nettype none

interface hbs_req_if #(
    parameter int KEY_W = hbs_pkg::UNIV_BITS_DEF
);
    logic                       valid;
    logic                       ready;
    logic [hbs_pkg::FUNC_W-1:0] func;
    logic [KEY_W-1:0]           key;

    modport source (output valid, output func, output key, input ready);
    modport sink   (input valid, input func, input key, output ready);
endinterface

interface hbs_rsp_if #(
    parameter int KEY_W = hbs_pkg::UNIV_BITS_DEF
);
    logic             valid;
    logic             ready;
    logic             found;
    logic [KEY_W-1:0] result_key;

    modport source (output valid, output found, output result_key, input ready);
    modport sink   (input valid, input found, input result_key, output ready);
endinterface

`default_nettype wire

>>> rtl/hbs_seq.sv
`default_nettype none

module hbs_seq (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire hbs_pkg::t_stat             i_stat,
    input  wire logic [hbs_pkg::FUNC_W-1:0] i_func,
    output hbs_pkg::t_uword                 o_ctrl
);

    hbs_pkg::t_step r_step;
    hbs_pkg::t_step n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= hbs_pkg::ST_CLEAR;
        end else begin
            r_step <= n_step;
        end
    end

    // next step
    always_comb begin
        n_step = o_ctrl.next;
        case (o_ctrl.cond)
            hbs_pkg::C_NONE: begin
                n_step = o_ctrl.next;
            end
            hbs_pkg::C_DISPATCH: begin
                if (i_stat.accept) begin
                    n_step = hbs_pkg::dispatch(i_func);
                end
            end
            hbs_pkg::C_CLEAR: begin
                if (i_stat.clr_last) begin
                    n_step = o_ctrl.jmp;
                end
            end
            hbs_pkg::C_UPDATE: begin
                if (i_stat.upd_stop) begin
                    n_step = o_ctrl.jmp;
                end
            end
            hbs_pkg::C_QUERY: begin
                if (i_stat.qry_emit) begin
                    n_step = o_ctrl.jmp;
                end else if (i_stat.qry_hit) begin
                    n_step = o_ctrl.alt;
                end
            end
            hbs_pkg::C_DESCEND: begin
                if (i_stat.dsc_emit) begin
                    n_step = o_ctrl.jmp;
                end
            end
            hbs_pkg::C_EMIT: begin
                if (i_stat.out_free) begin
                    n_step = o_ctrl.jmp;
                end
            end
            default: begin
                n_step = hbs_pkg::ST_IDLE;
            end
        endcase
    end

    // control word of the current step
    always_comb begin
        o_ctrl = hbs_pkg::ucode(r_step);
    end

endmodule

`default_nettype wire

>>> rtl/hierarchical_bitmap_set_core.sv
// Set of integer keys in [0, 2**UNIVERSE_BITS), kept as a tree of 64-bit bitmaps
// (ceil(UNIVERSE_BITS/6) levels) in one single-port memory, with the root as its last word.
// i_req carries one operation per transaction: func (insert, delete, predecessor,
// successor, minimum, maximum) and key. o_rsp carries found and result_key, one
// transaction for each query and none for insert, delete or an unused func code.
// A microcoded sequencer walks the tree one level at a time: a memory read,
// then evaluate and, for updates, write back in the same word.
// Each operation walks the tree as follows:
//   insert/delete: climb from the leaf over the levels touched, at most up to the root
//   min/max: descend from the root until an empty word or the leaf
//   predecessor/successor: climb from the leaf until a hit, then descend to the leaf
// One operation is in flight at a time; the memory port sets the pace.
// The response sits in an output register; the next request is taken while it waits,
// and the sequencer stalls on its next response until o_rsp is free.
// Reset clears the control state and starts a clearing pass that writes zero to every
// memory word (4161 words at 18 key bits), one a cycle, with i_req.ready low throughout.
`default_nettype none

module hierarchical_bitmap_set_core #(
    parameter int UNIVERSE_BITS = hbs_pkg::UNIV_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    hbs_req_if.sink    i_req,
    hbs_rsp_if.source  o_rsp
);

    localparam int WW     = hbs_pkg::WORD_W;
    localparam int DW     = hbs_pkg::DIGIT_W;
    localparam int KW     = UNIVERSE_BITS;
    localparam int LEVELS = (UNIVERSE_BITS + 5) / 6;
    localparam int LW     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int DEPTH  = hbs_pkg::lvl_base(UNIVERSE_BITS, LEVELS, hbs_pkg::MAX_LEVELS);
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    hbs_pkg::t_uword ctrl;
    hbs_pkg::t_stat  stat;

    logic [WW-1:0] r_mem [DEPTH];
    logic [WW-1:0] r_q;

    logic [hbs_pkg::FUNC_W-1:0] r_func, n_func;
    logic [KW-1:0]              r_x, n_x;
    logic [KW-1:0]              r_ans, n_ans;
    logic [LW-1:0]              r_lvl, n_lvl;
    logic                       r_found, n_found;
    logic [AW-1:0]              r_clr, n_clr;
    logic                       r_out_valid, n_out_valid;
    logic                       r_out_found, n_out_found;
    logic [KW-1:0]              r_out_key, n_out_key;

    logic [AW-1:0] addr;
    logic [AW-1:0] base;
    logic [KW-1:0] idx_mask;
    logic [KW-1:0] idx;
    logic [WW-1:0] wdata;
    logic [WW-1:0] bit_sel;
    logic [WW-1:0] mask_lo;
    logic [WW-1:0] qv;
    logic [DW-1:0] hit_pos;
    logic [DW-1:0] dsc_pos;
    logic [KW-1:0] hit_ans;
    logic          at_top;
    logic          at_leaf;
    logic          hit;
    logic          use_high;

    hbs_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .i_func  (i_req.func),
        .o_ctrl  (ctrl)
    );

    assign i_req.ready      = ctrl.in_rdy;
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.found      = r_out_found;
    assign o_rsp.result_key = r_out_key;

    // address of the word at the current level
    always_comb begin
        base     = AW'(hbs_pkg::lvl_base(UNIVERSE_BITS, LEVELS, int'(r_lvl)));
        idx_mask = KW'(hbs_pkg::lvl_words(UNIVERSE_BITS, LEVELS, int'(r_lvl)) - 1);
        idx      = ((ctrl.asel == hbs_pkg::ASEL_ANS) ? r_ans : (r_x >> DW)) & idx_mask;
        if (ctrl.asel == hbs_pkg::ASEL_CLR) begin
            addr = r_clr;
        end else begin
            addr = base + AW'(idx);
        end
    end

    // word evaluation
    always_comb begin
        at_top   = (r_lvl == LW'(LEVELS - 1));
        at_leaf  = (r_lvl == '0);
        bit_sel  = WW'(1) << r_x[DW-1:0];
        mask_lo  = bit_sel - WW'(1);
        use_high = r_func inside {hbs_pkg::FN_PRED, hbs_pkg::FN_MAX};
        if (r_func == hbs_pkg::FN_SUCC) begin
            qv      = r_q & ~(mask_lo | bit_sel);
            hit_pos = hbs_pkg::low_bit(qv);
        end else begin
            qv      = r_q & mask_lo;
            hit_pos = hbs_pkg::high_bit(qv);
        end
        hit     = (qv != '0);
        hit_ans = ((r_x >> DW) << DW) | KW'(hit_pos);
        dsc_pos = use_high ? hbs_pkg::high_bit(r_q) : hbs_pkg::low_bit(r_q);
        if (ctrl.wr_zero) begin
            wdata = '0;
        end else if (r_func == hbs_pkg::FN_DELETE) begin
            wdata = r_q & ~bit_sel;
        end else begin
            wdata = r_q | bit_sel;
        end
    end

    // status to the sequencer
    always_comb begin
        stat.accept   = i_req.valid && ctrl.in_rdy;
        stat.clr_last = (r_clr == AW'(DEPTH - 1));
        if (r_func == hbs_pkg::FN_DELETE) begin
            stat.upd_stop = ((r_q & ~bit_sel) != '0) || at_top;
        end else begin
            stat.upd_stop = ((r_q & bit_sel) != '0) || at_top;
        end
        stat.qry_emit = (hit && at_leaf) || (!hit && at_top);
        stat.qry_hit  = hit;
        stat.dsc_emit = (r_q == '0) || at_leaf;
        stat.out_free = !r_out_valid || o_rsp.ready;
    end

    always_comb begin
        n_func      = r_func;
        n_x         = r_x;
        n_ans       = r_ans;
        n_lvl       = r_lvl;
        n_found     = r_found;
        n_clr       = r_clr;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_found = r_out_found;
        n_out_key   = r_out_key;
        case (ctrl.dp)
            hbs_pkg::DP_CLEAR: begin
                n_clr = r_clr + AW'(1);
            end
            hbs_pkg::DP_LOAD: begin
                if (stat.accept) begin
                    n_func  = i_req.func;
                    n_x     = KW'(i_req.key);
                    n_ans   = '0;
                    n_found = 1'b0;
                    if (i_req.func inside {hbs_pkg::FN_MIN, hbs_pkg::FN_MAX}) begin
                        n_lvl = LW'(LEVELS - 1);
                    end else begin
                        n_lvl = '0;
                    end
                end
            end
            hbs_pkg::DP_UPDATE: begin
                if (!stat.upd_stop) begin
                    n_lvl = r_lvl + LW'(1);
                    n_x   = r_x >> DW;
                end
            end
            hbs_pkg::DP_QUERY: begin
                if (hit) begin
                    n_ans   = hit_ans;
                    n_found = 1'b1;
                    if (!at_leaf) begin
                        n_lvl = r_lvl - LW'(1);
                    end
                end else if (at_top) begin
                    n_ans   = '0;
                    n_found = 1'b0;
                end else begin
                    n_lvl = r_lvl + LW'(1);
                    n_x   = r_x >> DW;
                end
            end
            hbs_pkg::DP_DESCEND: begin
                if (r_q == '0) begin
                    n_ans   = '0;
                    n_found = 1'b0;
                end else begin
                    n_ans   = (r_ans << DW) | KW'(dsc_pos);
                    n_found = 1'b1;
                    if (!at_leaf) begin
                        n_lvl = r_lvl - LW'(1);
                    end
                end
            end
            hbs_pkg::DP_EMIT: begin
                if (stat.out_free) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_found;
                    n_out_key   = r_ans;
                end
            end
            default: begin
            end
        endcase
    end

    // bitmap memory
    always_ff @(posedge i_clk) begin
        if (ctrl.mem_wr) begin
            r_mem[addr] <= wdata;
        end
        if (ctrl.mem_rd) begin
            r_q <= r_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func      <= n_func;
        r_x         <= n_x;
        r_ans       <= n_ans;
        r_lvl       <= n_lvl;
        r_found     <= n_found;
        r_out_found <= n_out_found;
        r_out_key   <= n_out_key;
    end

endmodule

`default_nettype wire

>>> rtl/hbs_chk.sv
`default_nettype none

module hbs_chk #(
    parameter int KEY_W = hbs_pkg::UNIV_BITS_DEF
) (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_req_valid,
    input wire logic                       i_req_ready,
    input wire logic [hbs_pkg::FUNC_W-1:0] i_req_func,
    input wire logic                       i_rsp_valid,
    input wire logic                       i_rsp_ready,
    input wire logic                       i_rsp_found,
    input wire logic [KEY_W-1:0]           i_rsp_key
);

    // reset starts the clearing pass with nothing pending
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_req_ready && !i_rsp_valid)
        else $error("request taken or response shown right after reset");

    // one operation in flight
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready && (i_req_func <= hbs_pkg::FN_MAX)) |=> !i_req_ready)
        else $error("second request taken while an operation runs");

    // no response can follow the very transaction that started the operation
    a_no_instant_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready && !i_rsp_valid) |=> !i_rsp_valid)
        else $error("response appeared one cycle after request");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_rsp_found) && $stable(i_rsp_key)))
        else $error("stalled response changed");

endmodule

bind hierarchical_bitmap_set_core hbs_chk #(
    .KEY_W (UNIVERSE_BITS)
) u_hbs_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_req_func  (i_req.func),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_found (o_rsp.found),
    .i_rsp_key   (o_rsp.result_key)
);

`default_nettype wire

>>> sim/tb_top.sv
`default_nettype none

module tb_top;

    localparam int KEY_W          = hbs_pkg::UNIV_BITS_DEF;
    localparam int WORD_W         = hbs_pkg::WORD_W;
    localparam int DIGIT_W        = hbs_pkg::DIGIT_W;
    localparam int FUNC_W         = hbs_pkg::FUNC_W;
    localparam int LEVELS         = (KEY_W + DIGIT_W - 1) / DIGIT_W;
    localparam int LEAF_WORDS     = 1 << (KEY_W - DIGIT_W);
    localparam int MID_WORDS      = 1 << (KEY_W - 2 * DIGIT_W);
    localparam int WATCHDOG_LIMIT = 25000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int RANDOM_OPS     = 950;
    localparam int POOL_MAX       = 256;

    // func codes the block ignores
    localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;

    localparam logic [KEY_W-1:0] KEY_TOP = '1;

    typedef struct packed {
        logic             found;
        logic [KEY_W-1:0] key;
    } t_answer;

    logic i_clk;
    logic i_rst_n;

    hbs_req_if #(.KEY_W(KEY_W)) req_if ();
    hbs_rsp_if #(.KEY_W(KEY_W)) rsp_if ();

    hierarchical_bitmap_set_core #(
        .UNIVERSE_BITS(KEY_W)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    // shadow copy of the bitmap tree
    logic [WORD_W-1:0] leaf_map [LEAF_WORDS];
    logic [WORD_W-1:0] mid_map  [MID_WORDS];
    logic [WORD_W-1:0] root_map;

    t_answer          expected_answers [$];
    logic [KEY_W-1:0] live_keys [$];
    int unsigned      cluster_base [4];

    int unsigned fail_count;
    int unsigned quiet_cycles;
    int unsigned hold_off_len;
    bit          no_idle;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int unsigned lowest_set(input logic [WORD_W-1:0] w);
        int unsigned n;
        n = 0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (w[i]) begin
                n = i;
            end
        end
        return n;
    endfunction

    function automatic int unsigned highest_set(input logic [WORD_W-1:0] w);
        int unsigned n;
        n = 0;
        for (int i = 0; i < WORD_W; i++) begin
            if (w[i]) begin
                n = i;
            end
        end
        return n;
    endfunction

    function automatic logic [WORD_W-1:0] tree_word(input int lvl, input int unsigned idx);
        if (lvl == 0) begin
            return leaf_map[idx % LEAF_WORDS];
        end
        if (lvl >= LEVELS - 1) begin
            return root_map;
        end
        return mid_map[idx % MID_WORDS];
    endfunction

    function automatic void put_tree_word(input int lvl, input int unsigned idx,
                                          input logic [WORD_W-1:0] w);
        if (lvl == 0) begin
            leaf_map[idx % LEAF_WORDS] = w;
        end else if (lvl >= LEVELS - 1) begin
            root_map = w;
        end else begin
            mid_map[idx % MID_WORDS] = w;
        end
    endfunction

    function automatic logic [KEY_W-1:0] walk_down(input int from, input int unsigned ans,
                                                   input bit take_high);
        logic [WORD_W-1:0] w;
        for (int j = from; j >= 0; j--) begin
            w   = tree_word(j, ans);
            ans = ans * WORD_W + (take_high ? highest_set(w) : lowest_set(w));
        end
        return KEY_W'(ans);
    endfunction

    function automatic void apply_update(input logic [FUNC_W-1:0] op, input logic [KEY_W-1:0] k);
        int unsigned       x;
        logic [WORD_W-1:0] sel;
        logic [WORD_W-1:0] w;
        x = k;
        for (int lvl = 0; lvl < LEVELS; lvl++) begin
            sel = 64'd1 << (x % WORD_W);
            x   = x >> DIGIT_W;
            w   = tree_word(lvl, x);
            if (op == hbs_pkg::FN_INSERT) begin
                if ((w & sel) != '0) begin
                    break;
                end
                put_tree_word(lvl, x, w | sel);
            end else begin
                w = w & ~sel;
                put_tree_word(lvl, x, w);
                if (w != '0) begin
                    break;
                end
            end
        end
    endfunction

    function automatic t_answer predict_answer(input logic [FUNC_W-1:0] op,
                                               input logic [KEY_W-1:0] k);
        t_answer           a;
        int unsigned       x;
        int unsigned       b;
        int unsigned       ans;
        logic [WORD_W-1:0] w;
        logic [WORD_W-1:0] v;
        a.found = 1'b0;
        a.key   = '0;
        x       = k;
        if (op == hbs_pkg::FN_PRED || op == hbs_pkg::FN_SUCC) begin
            for (int lvl = 0; lvl < LEVELS; lvl++) begin
                b = x % WORD_W;
                x = x >> DIGIT_W;
                w = tree_word(lvl, x);
                if (op == hbs_pkg::FN_SUCC) begin
                    v = (w >> b) >> 1;
                end else begin
                    v = w & ((64'd1 << b) - 64'd1);
                end
                if (v != '0) begin
                    if (op == hbs_pkg::FN_SUCC) begin
                        ans = x * WORD_W + lowest_set(v) + b + 1;
                    end else begin
                        ans = x * WORD_W + highest_set(v);
                    end
                    a.found = 1'b1;
                    a.key   = walk_down(lvl - 1, ans, op == hbs_pkg::FN_PRED);
                    break;
                end
            end
        end else if (root_map != '0) begin
            a.found = 1'b1;
            a.key   = walk_down(LEVELS - 1, 0, op == hbs_pkg::FN_MAX);
        end
        return a;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle) begin
            return 0;
        end
        if (r < 45) begin
            return 0;
        end
        if (r < 85) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] k;
        k = KEY_W'($urandom);
        case ($urandom_range(0, 9))
            2, 3, 4, 5: begin
                k = KEY_W'(cluster_base[$urandom_range(0, 3)] + $urandom_range(0, 300));
            end
            6: begin
                k[DIGIT_W-1:0] = $urandom_range(0, 1) ? '1 : '0;
            end
            7: begin
                k[2*DIGIT_W-1:0] = $urandom_range(0, 1) ? '1 : '0;
            end
            8, 9: begin
                if (live_keys.size() > 0) begin
                    k = live_keys[$urandom_range(0, live_keys.size() - 1)];
                end
            end
            default: begin
            end
        endcase
        return k;
    endfunction

    function automatic logic [FUNC_W-1:0] pick_op();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            return hbs_pkg::FN_INSERT;
        end
        if (r < 45) begin
            return hbs_pkg::FN_DELETE;
        end
        if (r < 65) begin
            return hbs_pkg::FN_PRED;
        end
        if (r < 85) begin
            return hbs_pkg::FN_SUCC;
        end
        if (r < 90) begin
            return hbs_pkg::FN_MIN;
        end
        if (r < 95) begin
            return hbs_pkg::FN_MAX;
        end
        return $urandom_range(0, 1) ? FN_SPARE_HI : FN_SPARE_LO;
    endfunction

    // one transaction on the request side, shadow updated on acceptance
    task automatic issue_op(input logic [FUNC_W-1:0] op, input logic [KEY_W-1:0] k,
                            input int unsigned gap);
        req_if.valid <= 1'b1;
        req_if.func  <= op;
        req_if.key   <= k;
        do @(posedge i_clk); while (!req_if.ready);
        case (op)
            hbs_pkg::FN_INSERT: begin
                apply_update(op, k);
                live_keys.push_back(k);
                if (live_keys.size() > POOL_MAX) begin
                    void'(live_keys.pop_front());
                end
            end
            hbs_pkg::FN_DELETE: begin
                apply_update(op, k);
            end
            hbs_pkg::FN_PRED, hbs_pkg::FN_SUCC, hbs_pkg::FN_MIN, hbs_pkg::FN_MAX: begin
                expected_answers.push_back(predict_answer(op, k));
            end
            default: begin
            end
        endcase
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drain();
        req_if.valid <= 1'b0;
        while (expected_answers.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_directed_edges();
        issue_op(hbs_pkg::FN_MIN, '0, pick_gap());
        issue_op(hbs_pkg::FN_MAX, KEY_TOP, pick_gap());
        issue_op(hbs_pkg::FN_PRED, KEY_TOP, pick_gap());
        issue_op(hbs_pkg::FN_SUCC, '0, pick_gap());
        issue_op(hbs_pkg::FN_INSERT, '0, pick_gap());
        issue_op(hbs_pkg::FN_INSERT, KEY_TOP, pick_gap());
        issue_op(hbs_pkg::FN_INSERT, KEY_W'(63), pick_gap());
        issue_op(hbs_pkg::FN_INSERT, KEY_W'(64), pick_gap());
        issue_op(hbs_pkg::FN_INSERT, KEY_W'(4095), pick_gap());
        issue_op(hbs_pkg::FN_INSERT, KEY_W'(4096), pick_gap());
        issue_op(hbs_pkg::FN_INSERT, KEY_W'(131072), pick_gap());
        issue_op(hbs_pkg::FN_INSERT, KEY_W'(63), pick_gap());
        issue_op(hbs_pkg::FN_DELETE, KEY_W'(5), pick_gap());
        issue_op(hbs_pkg::FN_PRED, '0, pick_gap());
        issue_op(hbs_pkg::FN_SUCC, KEY_TOP, pick_gap());
        issue_op(hbs_pkg::FN_PRED, KEY_TOP, pick_gap());
        issue_op(hbs_pkg::FN_SUCC, '0, pick_gap());
        issue_op(hbs_pkg::FN_PRED, KEY_W'(4096), pick_gap());
        issue_op(hbs_pkg::FN_SUCC, KEY_W'(4095), pick_gap());
        issue_op(hbs_pkg::FN_PRED, KEY_W'(131072), pick_gap());
        issue_op(hbs_pkg::FN_MIN, KEY_TOP, pick_gap());
        issue_op(hbs_pkg::FN_MAX, '0, pick_gap());
        issue_op(FN_SPARE_LO, KEY_TOP, pick_gap());
        issue_op(FN_SPARE_HI, KEY_TOP, pick_gap());
        issue_op(hbs_pkg::FN_DELETE, KEY_TOP, pick_gap());
        issue_op(hbs_pkg::FN_MAX, '0, pick_gap());
        wait_drain();
    endtask

    task automatic test_random_mix();
        int unsigned      done;
        logic [FUNC_W-1:0] op;
        logic [KEY_W-1:0]  k;
        done = 0;
        foreach (cluster_base[i]) begin
            cluster_base[i] = $urandom_range(0, (1 << KEY_W) - 1);
        end
        while (done < RANDOM_OPS) begin
            no_idle = (done >= 300 && done < 420);
            op      = pick_op();
            k       = pick_key();
            if (op == hbs_pkg::FN_DELETE && live_keys.size() > 0 &&
                $urandom_range(0, 9) < 7) begin
                k = live_keys[$urandom_range(0, live_keys.size() - 1)];
            end
            issue_op(op, k, pick_gap());
            if (op <= hbs_pkg::FN_MAX) begin
                done++;
            end
        end
        no_idle = 1'b0;
        wait_drain();
    endtask

    // response side held off while requests keep coming
    task automatic test_output_backpressure();
        hold_off_len = 400;
        repeat (24) begin
            issue_op($urandom_range(0, 1) ? hbs_pkg::FN_PRED : hbs_pkg::FN_SUCC,
                     pick_key(), 0);
        end
        wait_drain();
    endtask

    // empty the set one extreme at a time, then query the empty set
    task automatic test_set_drain();
        bit take_high;
        while (root_map != '0) begin
            take_high = $urandom_range(0, 1);
            issue_op(hbs_pkg::FN_DELETE, walk_down(LEVELS - 1, 0, take_high), pick_gap());
            if ($urandom_range(0, 3) == 0) begin
                issue_op($urandom_range(0, 1) ? hbs_pkg::FN_PRED : hbs_pkg::FN_SUCC,
                         pick_key(), pick_gap());
            end
        end
        live_keys.delete();
        issue_op(hbs_pkg::FN_MIN, pick_key(), pick_gap());
        issue_op(hbs_pkg::FN_MAX, pick_key(), pick_gap());
        issue_op(hbs_pkg::FN_PRED, KEY_TOP, pick_gap());
        issue_op(hbs_pkg::FN_SUCC, '0, pick_gap());
        wait_drain();
    endtask

    // response ready with random stalls
    initial begin
        int unsigned gap;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_len > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (hold_off_len) @(posedge i_clk);
                hold_off_len = 0;
            end else if (no_idle) begin
                rsp_if.ready <= 1'b1;
            end else begin
                gap = pick_gap();
                if (gap == 0) begin
                    rsp_if.ready <= 1'b1;
                end else begin
                    rsp_if.ready <= 1'b0;
                    repeat (gap - 1) @(posedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_answers.size() == 0) begin
                $error("unexpected response: found %0b result_key %0d",
                       rsp_if.found, rsp_if.result_key);
                fail_count++;
            end else begin
                want = expected_answers.pop_front();
                if (rsp_if.found !== want.found) begin
                    $error("found: expected %0b, got %0b", want.found, rsp_if.found);
                    fail_count++;
                end
                if (rsp_if.result_key !== want.key) begin
                    $error("result_key: expected %0d, got %0d", want.key, rsp_if.result_key);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        foreach (leaf_map[i]) begin
            leaf_map[i] = '0;
        end
        foreach (mid_map[i]) begin
            mid_map[i] = '0;
        end
        root_map     = '0;
        fail_count   = 0;
        quiet_cycles = 0;
        hold_off_len = 0;
        no_idle      = 1'b0;
        i_rst_n      <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.func  <= hbs_pkg::FN_INSERT;
        req_if.key   <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_edges();
        test_random_mix();
        test_output_backpressure();
        test_set_drain();

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
